FILE: rtl/maf_pkg.sv
// shared constants for the moving average filter
`default_nettype none

package maf_pkg;

    // build-time defaults for the top level parameters
    localparam int MAX_WINDOW_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // window length register
    localparam int               WIN_LEN_W     = 6;
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 6'd11;

endpackage

`default_nettype wire

FILE: rtl/maf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/maf_div.sv
// serial signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module maf_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DIVIDEND_W-1:0] i_dividend,
    input  wire logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic signed      [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic                  r_neg;

    logic [DIVIDEND_W-1:0] w_mag;
    logic [DIVISOR_W:0]    w_rem_sh;
    logic                  w_fit;
    logic [DIVISOR_W:0]    w_rem_sub;

    // magnitude of the dividend; the most negative value maps to itself, read unsigned
    assign w_mag = i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend) : DIVIDEND_W'(i_dividend);

    // one restoring step
    assign w_rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_fit     = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[DIVIDEND_W-1];
        end else if (r_busy) begin
            r_rem <= w_fit ? w_rem_sub[DIVISOR_W-1:0] : w_rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

FILE: rtl/moving_average_filter.sv
// boxcar moving average filter, top level
// ---------------------------------------------------------------------------
// takes one signed sample per input word, keeps the last MAX_WINDOW samples
// in a ring ram and a running sum of the current window. once window_len
// samples have arrived since the last restart (or the last window_len write),
// every sample yields one average word: window sum / window_len, truncated
// toward zero. that value is the centered average for the sample half a
// window back. a window_len of 0 acts as 1, above MAX_WINDOW acts as
// MAX_WINDOW. tuser marks restart, which clears fill count, sum and ring
// pointer before the sample is taken in. writing window_len also clears
// fill count and sum. each input word that yields an average passes through
// these steps: accept, the ring read of the sample leaving the window, the
// one-bit-per-cycle divider and its done flag, and the hand-off of the
// result to the output register. samples that give no result go back to
// idle after the ring read. no new word is taken until the current one is
// done. the output register lets the next word in while a result waits;
// the filter stalls only when a second result is ready before the first
// has been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module moving_average_filter #(
    parameter int MAX_WINDOW   = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    // sample stream in
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [TDATA_W-1:0]            s_axis_tdata,  // sample
    input  wire logic [0:0]                    s_axis_tuser,  // restart

    // average stream out
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [TDATA_W-1:0]            m_axis_tdata,  // average

    // window length write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [maf_pkg::WIN_LEN_W-1:0] i_cfg_data     // window_len
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int OFF_W = LEN_W + 1;
    localparam int SUM_W = SAMPLE_WIDTH + PTR_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // ready for a word
    localparam logic [1:0] S_READ = 2'd1;  // oldest sample on ram output
    localparam logic [1:0] S_DIV  = 2'd2;  // divider running
    localparam logic [1:0] S_OUT  = 2'd3;  // quotient waits for output register

    logic [1:0]                    r_state, n_state;
    logic [maf_pkg::WIN_LEN_W-1:0] r_win_len, n_win_len;
    logic [PTR_W-1:0]              r_wp, n_wp;
    logic [LEN_W-1:0]              r_fill, n_fill;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic                          r_full, n_full;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                          r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0]       r_out_data;

    logic                          w_in_acc;
    logic                          w_cfg_acc;
    logic [LEN_W-1:0]              w_len;
    logic [PTR_W-1:0]              w_wp_eff;
    logic [LEN_W-1:0]              w_fill_eff;
    logic [OFF_W-1:0]              w_wp_ext;
    logic [OFF_W-1:0]              w_len_ext;
    logic [OFF_W-1:0]              w_oldest_ext;
    logic [PTR_W-1:0]              w_oldest;
    logic [SAMPLE_WIDTH-1:0]       w_rd_data;
    logic signed [SAMPLE_WIDTH-1:0] w_old;
    logic [PTR_W-1:0]              w_wp_inc;
    logic                          w_ram_wr;
    logic                          w_div_start;
    logic                          w_div_done;
    logic signed [SUM_W-1:0]       w_quot;
    logic                          w_emits;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);

    // effective window: 0 acts as 1, clipped to ring depth
    always_comb begin
        if (r_win_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_win_len) > 32'(MAX_WINDOW)) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(r_win_len);
        end
    end

    // pointer and fill after a possible restart of this word
    assign w_wp_eff   = s_axis_tuser[0] ? '0 : r_wp;
    assign w_fill_eff = s_axis_tuser[0] ? '0 : r_fill;

    // slot of the sample leaving the window, wrapping around the ring
    assign w_wp_ext  = OFF_W'(w_wp_eff);
    assign w_len_ext = OFF_W'(w_len);
    assign w_oldest_ext = (w_wp_ext >= w_len_ext) ? (w_wp_ext - w_len_ext)
                        : (w_wp_ext + OFF_W'(MAX_WINDOW) - w_len_ext);
    assign w_oldest = w_oldest_ext[PTR_W-1:0];

    assign w_wp_inc = (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : (r_wp + 1'b1);

    assign w_old   = $signed(w_rd_data);
    assign w_emits = r_full || ((r_fill + 1'b1) >= w_len);

    // ring is read on accept and written in the following cycle, so a full window
    // sees the old sample before it is overwritten
    assign w_ram_wr    = (r_state == S_READ);
    assign w_div_start = (r_state == S_READ) && w_emits;

    maf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (r_wp),
        .i_wr_data (r_sample),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_oldest),
        .o_rd_data (w_rd_data)
    );

    maf_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_win_len   = r_win_len;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_full      = r_full;
        n_out_valid = r_out_valid;

        // output register drains independently of the sequencer
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_wp    = w_wp_eff;
                    n_fill  = w_fill_eff;
                    n_sum   = s_axis_tuser[0] ? '0 : r_sum;
                    n_full  = (w_fill_eff >= w_len);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // drop the leaving sample once full, add the new one
                n_sum = r_sum - (r_full ? SUM_W'(w_old) : '0) + SUM_W'(r_sample);
                n_wp  = w_wp_inc;
                if (!r_full) begin
                    n_fill = r_fill + 1'b1;
                end
                n_state = w_emits ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // window length write restarts the fill
        if (w_cfg_acc) begin
            n_win_len = i_cfg_data;
            n_fill    = '0;
            n_sum     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_len   <= maf_pkg::WIN_LEN_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win_len   <= n_win_len;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
        end
        if ((r_state == S_OUT) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= w_quot[SAMPLE_WIDTH-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);

endmodule

`default_nettype wire
